[hdl/trsc_pkg.sv]
// Shared types and codes for the register/stack instruction engine.
// Operation, register and error codes plus the structs passed between
// the issue stage and the execute stage. No dependencies.
package trsc_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned OP_W   = 4;
   localparam int unsigned REG_W  = 3;
   localparam int unsigned ERR_W  = 2;

   localparam logic [OP_W-1:0] OP_LDA  = 4'd0;
   localparam logic [OP_W-1:0] OP_LDB  = 4'd1;
   localparam logic [OP_W-1:0] OP_LDC  = 4'd2;
   localparam logic [OP_W-1:0] OP_LDS  = 4'd3;
   localparam logic [OP_W-1:0] OP_LDO  = 4'd4;
   localparam logic [OP_W-1:0] OP_PUSH = 4'd5;
   localparam logic [OP_W-1:0] OP_PULL = 4'd6;
   localparam logic [OP_W-1:0] OP_INC  = 4'd7;
   localparam logic [OP_W-1:0] OP_DEC  = 4'd8;
   localparam logic [OP_W-1:0] OP_SUM  = 4'd9;
   localparam logic [OP_W-1:0] OP_OUT  = 4'd10;

   localparam logic [REG_W-1:0] REG_A = 3'd0;
   localparam logic [REG_W-1:0] REG_B = 3'd1;
   localparam logic [REG_W-1:0] REG_C = 3'd2;
   localparam logic [REG_W-1:0] REG_S = 3'd3;
   localparam logic [REG_W-1:0] REG_O = 3'd4;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_SELF  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd3;

   // Execute-stage contents: request fields plus decisions taken at issue.
   typedef struct packed {
      logic              valid;
      logic [OP_W-1:0]   op;
      logic              is_reg;
      logic [REG_W-1:0]  src_reg;
      logic [DATA_W-1:0] imm;
      logic [ERR_W-1:0]  err;
      logic              push_ok;
      logic              pull_ok;
      logic              fwd;
      logic [DATA_W-1:0] fwd_data;
   } issue_type;

   // Stack write from the execute stage.
   typedef struct packed {
      logic              we;
      logic [DATA_W-1:0] data;
   } wr_type;

endpackage

[hdl/trsc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module trsc_ram #(
   parameter int unsigned WIDTH  = 32,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/trsc_issue.sv]
// Issue stage: request decode, stack pointer, stack read issue and the
// execute-stage register. Depends on trsc_pkg.
module trsc_issue #(
   parameter int unsigned STACK_DEPTH = 16,
   parameter int unsigned CNT_W       = 5,
   parameter int unsigned ADDR_W      = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [trsc_pkg::OP_W-1:0]    req_type,
   input  logic                         req_src_is_reg,
   input  logic [trsc_pkg::REG_W-1:0]   req_src_reg,
   input  logic [trsc_pkg::DATA_W-1:0]  req_imm_value,
   input  logic                         adv,
   input  trsc_pkg::wr_type             wr,
   output trsc_pkg::issue_type          q,
   output logic [ADDR_W-1:0]            wr_addr,
   output logic                         rd_en,
   output logic [ADDR_W-1:0]            rd_addr
);
   import trsc_pkg::*;

   issue_type         q_ff, q_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              accept;
   logic              src_ok;
   logic              full;
   logic [ERR_W-1:0]  dec_err;
   logic              dec_push;
   logic              dec_pull;

   assign req_ready = !q_ff.valid || adv;
   assign accept    = req_valid && req_ready;
   assign src_ok    = req_src_reg <= REG_O;
   assign full      = count_ff >= CNT_W'(STACK_DEPTH);
   assign rd_addr   = ADDR_W'(count_ff - CNT_W'(1));
   assign rd_en     = accept;

   always_comb begin
      dec_err  = ERR_NONE;
      dec_push = 1'b0;
      dec_pull = 1'b0;
      unique case (req_type) inside
         [OP_LDA:OP_LDO]: begin
            if (req_src_is_reg && {1'b0, req_src_reg} == req_type) begin
               dec_err = ERR_SELF;
            end
         end
         OP_PUSH: begin
            if (!req_src_is_reg || src_ok) begin
               if (full) begin
                  dec_err = ERR_FULL;
               end else begin
                  dec_push = 1'b1;
               end
            end
         end
         OP_PULL: begin
            if (count_ff == '0) begin
               dec_err = ERR_EMPTY;
            end else begin
               dec_pull = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      q_in          = q_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      if (accept) begin
         q_in.valid    = 1'b1;
         q_in.op       = req_type;
         q_in.is_reg   = req_src_is_reg;
         q_in.src_reg  = req_src_reg;
         q_in.imm      = req_imm_value;
         q_in.err      = dec_err;
         q_in.push_ok  = dec_push;
         q_in.pull_ok  = dec_pull;
         // the entry being read may be written by the push leaving execute now
         q_in.fwd      = dec_pull && wr.we && (addr_ff == rd_addr);
         q_in.fwd_data = wr.data;
         addr_in       = dec_push ? count_ff[ADDR_W-1:0] : rd_addr;
         if (dec_push) begin
            count_in = count_ff + CNT_W'(1);
         end else if (dec_pull) begin
            count_in = count_ff - CNT_W'(1);
         end
      end else if (adv) begin
         q_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
         count_ff   <= '0;
      end else begin
         q_ff.valid <= q_in.valid;
         count_ff   <= count_in;
      end
      q_ff.op       <= q_in.op;
      q_ff.is_reg   <= q_in.is_reg;
      q_ff.src_reg  <= q_in.src_reg;
      q_ff.imm      <= q_in.imm;
      q_ff.err      <= q_in.err;
      q_ff.push_ok  <= q_in.push_ok;
      q_ff.pull_ok  <= q_in.pull_ok;
      q_ff.fwd      <= q_in.fwd;
      q_ff.fwd_data <= q_in.fwd_data;
      addr_ff       <= addr_in;
   end

   assign q       = q_ff;
   assign wr_addr = addr_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      q_ff.valid && !adv |=> q_ff.valid && $stable(q_ff.imm) && $stable(q_ff.op))
      else $error("execute stage changed while stalled");

   a_fwd_pull: assert property (@(posedge clock) disable iff (reset)
      q_ff.valid && q_ff.fwd |-> q_ff.pull_ok)
      else $error("forward flagged on a non-pull request");

endmodule

[hdl/trsc_exec.sv]
// Execute stage: the five working registers, stack write data and the
// response register. Depends on trsc_pkg.
module trsc_exec (
   input  logic                         clock,
   input  logic                         reset,
   input  trsc_pkg::issue_type          q,
   input  logic [trsc_pkg::DATA_W-1:0]  rd_data,
   output logic                         adv,
   output trsc_pkg::wr_type             wr,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [trsc_pkg::ERR_W-1:0]   rsp_error_code,
   output logic                         rsp_print_valid,
   output logic [trsc_pkg::DATA_W-1:0]  rsp_print_value
);
   import trsc_pkg::*;

   logic [DATA_W-1:0] reg_a_ff, reg_b_ff, reg_c_ff, reg_s_ff, reg_o_ff;
   logic [DATA_W-1:0] reg_a_in, reg_b_in, reg_c_in, reg_s_in, reg_o_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ERR_W-1:0]  err_ff;
   logic              pvalid_ff;
   logic [DATA_W-1:0] pvalue_ff;
   logic [DATA_W-1:0] src_val;
   logic [DATA_W-1:0] pull_val;
   logic              src_ok;
   logic              tgt_en;
   logic [REG_W-1:0]  tgt_sel;
   logic [DATA_W-1:0] tgt_val;

   assign adv      = q.valid && (!rsp_valid_ff || rsp_ready);
   assign src_ok   = q.src_reg <= REG_O;
   assign pull_val = q.fwd ? q.fwd_data : rd_data;

   always_comb begin
      unique case (q.src_reg)
         REG_A:   src_val = reg_a_ff;
         REG_B:   src_val = reg_b_ff;
         REG_C:   src_val = reg_c_ff;
         REG_S:   src_val = reg_s_ff;
         REG_O:   src_val = reg_o_ff;
         default: src_val = '0;
      endcase
   end

   assign wr.we   = adv && q.push_ok;
   assign wr.data = q.is_reg ? src_val : q.imm;

   // one register at most changes per request
   always_comb begin
      tgt_en  = 1'b0;
      tgt_sel = REG_S;
      tgt_val = '0;
      unique case (q.op) inside
         [OP_LDA:OP_LDO]: begin
            tgt_en  = !q.is_reg || (q.err == ERR_NONE && src_ok);
            tgt_sel = q.op[REG_W-1:0];
            tgt_val = q.is_reg ? src_val : q.imm;
         end
         OP_PULL: begin
            tgt_en  = q.pull_ok;
            tgt_val = pull_val;
         end
         OP_INC: begin
            tgt_en  = q.is_reg && src_ok;
            tgt_sel = q.src_reg;
            tgt_val = src_val + DATA_W'(1);
         end
         OP_DEC: begin
            tgt_en  = q.is_reg && src_ok;
            tgt_sel = q.src_reg;
            tgt_val = src_val - DATA_W'(1);
         end
         OP_SUM: begin
            tgt_en  = 1'b1;
            tgt_val = reg_a_ff + reg_b_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      reg_a_in = reg_a_ff;
      reg_b_in = reg_b_ff;
      reg_c_in = reg_c_ff;
      reg_s_in = reg_s_ff;
      reg_o_in = reg_o_ff;
      if (adv && tgt_en) begin
         unique case (tgt_sel)
            REG_A:   reg_a_in = tgt_val;
            REG_B:   reg_b_in = tgt_val;
            REG_C:   reg_c_in = tgt_val;
            REG_S:   reg_s_in = tgt_val;
            REG_O:   reg_o_in = tgt_val;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_a_ff     <= '0;
         reg_b_ff     <= '0;
         reg_c_ff     <= '0;
         reg_s_ff     <= '0;
         reg_o_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         reg_a_ff     <= reg_a_in;
         reg_b_ff     <= reg_b_in;
         reg_c_ff     <= reg_c_in;
         reg_s_ff     <= reg_s_in;
         reg_o_ff     <= reg_o_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         err_ff    <= q.err;
         pvalid_ff <= q.op == OP_OUT;
         pvalue_ff <= (q.op == OP_OUT) ? reg_o_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_error_code  = err_ff;
   assign rsp_print_valid = pvalid_ff;
   assign rsp_print_value = pvalue_ff;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   a_sum: assert property (@(posedge clock) disable iff (reset)
      adv && q.op == OP_SUM |=> reg_s_ff == $past(reg_a_ff + reg_b_ff))
      else $error("sum result wrong");

   a_err_no_change: assert property (@(posedge clock) disable iff (reset)
      adv && q.err != ERR_NONE |=> $stable(reg_a_ff) && $stable(reg_b_ff)
         && $stable(reg_c_ff) && $stable(reg_s_ff) && $stable(reg_o_ff))
      else $error("register changed on an error request");

endmodule

[hdl/tiny_register_stack_cpu.sv]
// Top level of the register/stack instruction engine: issue stage, execute
// stage and stack RAM. Depends on trsc_pkg, trsc_issue, trsc_exec, trsc_ram.
//
// Usage: each request on the req_ channel is one decoded instruction
// (operation, operand select and immediate). Each request gives exactly one
// response on the rsp_ channel with an error code and, for out, the value
// of register O. Both channels use valid/ready.
// Flow: an accepted request is decoded and registered into the execute
// stage, then executed into the response register.
// Throughput: one request per cycle, sustained while responses are taken,
// for any operation mix; the stack pointer moves at issue and the stack
// RAM read for a pull is issued then, and a pull that directly follows a
// push takes the pushed value from a bypass rather than the RAM.
// Reset: registers A, B, C, S, O and the stack count clear; stack contents
// are not cleared and are only read below the count.
// Stall: when rsp_ready is low the response holds; the execute stage then
// holds too and req_ready drops until the response is taken.
module tiny_register_stack_cpu #(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [trsc_pkg::OP_W-1:0]    req_type,
   input  logic                         req_src_is_reg,
   input  logic [trsc_pkg::REG_W-1:0]   req_src_reg,
   input  logic signed [trsc_pkg::DATA_W-1:0] req_imm_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [trsc_pkg::ERR_W-1:0]   rsp_error_code,
   output logic                         rsp_print_valid,
   output logic signed [trsc_pkg::DATA_W-1:0] rsp_print_value
);
   import trsc_pkg::*;

   localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   issue_type         q;
   wr_type            wr;
   logic              adv;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic [DATA_W-1:0] print_value;

   trsc_issue #(
      .STACK_DEPTH (STACK_DEPTH),
      .CNT_W       (CNT_W),
      .ADDR_W      (ADDR_W)
   ) u_issue (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_src_is_reg (req_src_is_reg),
      .req_src_reg    (req_src_reg),
      .req_imm_value  (DATA_W'($unsigned(req_imm_value))),
      .adv            (adv),
      .wr             (wr),
      .q              (q),
      .wr_addr        (wr_addr),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr)
   );

   trsc_ram #(
      .WIDTH  (DATA_W),
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr.we),
      .wr_addr (wr_addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   trsc_exec u_exec (
      .clock           (clock),
      .reset           (reset),
      .q               (q),
      .rd_data         (rd_data),
      .adv             (adv),
      .wr              (wr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_error_code  (rsp_error_code),
      .rsp_print_valid (rsp_print_valid),
      .rsp_print_value (print_value)
   );

   assign rsp_print_value = $signed(print_value);

endmodule

[tb/instruction_checker.sv]
// Checker for the register/stack instruction engine: watches the request and
// response channels, predicts every response and compares it field by field.
// Depends on trsc_pkg.
module instruction_checker #(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [trsc_pkg::OP_W-1:0]           req_type,
   input  logic                                req_src_is_reg,
   input  logic [trsc_pkg::REG_W-1:0]          req_src_reg,
   input  logic signed [trsc_pkg::DATA_W-1:0]  req_imm_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [trsc_pkg::ERR_W-1:0]          rsp_error_code,
   input  logic                                rsp_print_valid,
   input  logic signed [trsc_pkg::DATA_W-1:0]  rsp_print_value,
   output int                                  outstanding,
   output int                                  failures
);
   import trsc_pkg::*;

   localparam int MAX_PRINTED = 50;

   typedef struct packed {
      logic [ERR_W-1:0]  error_code;
      logic              print_valid;
      logic [DATA_W-1:0] print_value;
   } result_type;

   logic [DATA_W-1:0] regs [0:int'(REG_O)];
   logic [DATA_W-1:0] stack_mem [0:STACK_DEPTH-1];
   int unsigned       stack_used;
   result_type        expected_results [$];

   initial begin
      failures    = 0;
      outstanding = 0;
      stack_used  = 0;
   end

   task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (failures < MAX_PRINTED)
         $display("mismatch on %s: got %h, want %h at %0t", field, got, want, $time);
      failures++;
   endtask

   // Apply one instruction to the shadow machine and return its response.
   function automatic result_type execute_instruction(input logic [OP_W-1:0] op,
                                                      input logic is_reg,
                                                      input logic [REG_W-1:0] sel,
                                                      input logic [DATA_W-1:0] imm);
      result_type        res;
      logic              src_ok;
      logic [DATA_W-1:0] operand;
      res     = '0;
      src_ok  = (sel <= REG_O);
      operand = !is_reg ? imm : (src_ok ? regs[sel] : '0);
      case (op)
         OP_LDA, OP_LDB, OP_LDC, OP_LDS, OP_LDO: begin
            if (is_reg && sel == op[REG_W-1:0])
               res.error_code = ERR_SELF;
            else if (!is_reg || src_ok)
               regs[op[REG_W-1:0]] = operand;
         end
         OP_PUSH: begin
            if (!is_reg || src_ok) begin
               if (stack_used >= STACK_DEPTH) begin
                  res.error_code = ERR_FULL;
               end else begin
                  stack_mem[stack_used] = operand;
                  stack_used++;
               end
            end
         end
         OP_PULL: begin
            if (stack_used == 0) begin
               res.error_code = ERR_EMPTY;
            end else begin
               stack_used--;
               regs[REG_S] = stack_mem[stack_used];
            end
         end
         OP_INC, OP_DEC: begin
            if (is_reg && src_ok)
               regs[sel] = (op == OP_INC) ? regs[sel] + DATA_W'(1)
                                          : regs[sel] - DATA_W'(1);
         end
         OP_SUM: regs[REG_S] = regs[REG_A] + regs[REG_B];
         OP_OUT: begin
            res.print_valid = 1'b1;
            res.print_value = regs[REG_O];
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      result_type predicted;
      if (reset) begin
         foreach (regs[i]) regs[i] = '0;
         stack_used = 0;
         expected_results.delete();
      end else begin
         // A response can never belong to a request taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("response with nothing pending",
                               DATA_W'(rsp_error_code), '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_error_code !== want.error_code)
                  report_mismatch("error_code", DATA_W'(rsp_error_code),
                                  DATA_W'(want.error_code));
               if (rsp_print_valid !== want.print_valid)
                  report_mismatch("print_valid", DATA_W'(rsp_print_valid),
                                  DATA_W'(want.print_valid));
               if (rsp_print_value !== want.print_value)
                  report_mismatch("print_value", rsp_print_value, want.print_value);
            end
         end
         if (req_valid && req_ready) begin
            predicted = execute_instruction(req_type, req_src_is_reg,
                                            req_src_reg, req_imm_value);
            expected_results.insert(expected_results.size(), predicted);
         end
      end
      outstanding = expected_results.size();
   end

endmodule

[tb/testbench.sv]
// Top of the instruction engine test: clock, reset, request and response
// drivers, directed and random programs, verdict. Depends on trsc_pkg,
// tiny_register_stack_cpu and instruction_checker.
module testbench;
   import trsc_pkg::*;

   localparam int unsigned STACK_DEPTH = 16;
   localparam int          CYCLE_LIMIT = 200000;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [OP_W-1:0]   req_type       = '0;
   logic              req_src_is_reg = 1'b0;
   logic [REG_W-1:0]  req_src_reg    = '0;
   logic [DATA_W-1:0] req_imm_value  = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [ERR_W-1:0]  rsp_error_code;
   logic              rsp_print_valid;
   logic [DATA_W-1:0] rsp_print_value;

   int outstanding;
   int failures;
   int items_sent    = 0;
   int rsp_hold_left = 0;
   int cycle_count   = 0;
   bit steady        = 1'b0;

   tiny_register_stack_cpu #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_src_is_reg (req_src_is_reg),
      .req_src_reg    (req_src_reg),
      .req_imm_value  (req_imm_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_error_code (rsp_error_code),
      .rsp_print_valid(rsp_print_valid),
      .rsp_print_value(rsp_print_value)
   );

   instruction_checker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_src_is_reg (req_src_is_reg),
      .req_src_reg    (req_src_reg),
      .req_imm_value  (req_imm_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_error_code (rsp_error_code),
      .rsp_print_valid(rsp_print_valid),
      .rsp_print_value(rsp_print_value),
      .outstanding    (outstanding),
      .failures       (failures)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response side: long hold when asked, ready if steady, else random stalls.
   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 35);
         end
      end
   end

   // Offer one request and hold it until taken; return at the next falling edge.
   task automatic offer(input logic [OP_W-1:0] op, input logic is_reg,
                        input logic [REG_W-1:0] sel, input logic [DATA_W-1:0] imm);
      if (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(99) < 90) ? 1 : $urandom_range(2, 8)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= op;
      req_src_is_reg <= is_reg;
      req_src_reg    <= sel;
      req_imm_value  <= imm;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   function automatic logic [DATA_W-1:0] rand_value();
      case ($urandom_range(7))
         0: return '0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly real registers, now and then an unused register number.
   function automatic logic [REG_W-1:0] rand_reg();
      if ($urandom_range(19) == 0)
         return REG_W'($urandom_range(int'(REG_O) + 1, (1 << REG_W) - 1));
      return REG_W'($urandom_range(REG_A, REG_O));
   endfunction

   task automatic random_program(input int upto);
      int              n;
      int              pick;
      logic [OP_W-1:0] op;
      while (items_sent < upto) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            offer(OP_W'($urandom), 1'($urandom), REG_W'($urandom), $urandom);
         end else if (pick < 25) begin
            n = $urandom_range(4, 20);
            repeat (n) offer(OP_PUSH, 1'($urandom_range(1)), rand_reg(), rand_value());
         end else if (pick < 38) begin
            n = $urandom_range(4, 20);
            repeat (n) offer(OP_PULL, 1'($urandom_range(1)), REG_W'($urandom), $urandom);
         end else begin
            op = OP_W'($urandom_range(OP_LDA, OP_OUT));
            offer(op, (op == OP_INC || op == OP_DEC) ? ($urandom_range(9) != 0)
                                                     : 1'($urandom_range(1)),
                  rand_reg(), rand_value());
         end
      end
   endtask

   initial begin : stimulus
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer(OP_OUT, 1'b0, REG_A, '0);
      offer(OP_LDA, 1'b0, REG_A, 32'h7FFF_FFFF);
      offer(OP_LDB, 1'b0, REG_A, 32'h8000_0000);
      offer(OP_SUM, 1'b0, REG_A, '0);
      offer(OP_LDO, 1'b1, REG_S, '0);
      offer(OP_OUT, 1'b1, REG_O, '1);
      offer(OP_INC, 1'b1, REG_O, '0);
      offer(OP_LDA, 1'b1, REG_A, '0);
      offer(OP_LDC, 1'b1, REG_A, '0);
      offer(OP_DEC, 1'b1, REG_B, '0);
      offer(OP_INC, 1'b1, REG_A, '0);
      offer(OP_INC, 1'b0, REG_A, '1);
      offer(OP_DEC, 1'b1, '1, '0);
      offer(OP_LDO, 1'b1, REG_W'(int'(REG_O) + 1), '1);
      offer(OP_PUSH, 1'b1, REG_W'(int'(REG_O) + 2), '0);
      offer(OP_PULL, 1'b0, REG_A, '0);
      offer(OP_PUSH, 1'b1, REG_C, '0);
      offer(OP_PUSH, 1'b0, REG_A, '1);
      offer(OP_PULL, 1'b0, REG_A, '0);
      offer(OP_PULL, 1'b1, REG_O, '0);
      offer(OP_PULL, 1'b0, REG_A, '0);
      offer(OP_LDO, 1'b1, REG_S, '0);
      offer(OP_OUT, 1'b0, REG_A, '0);
      offer(OP_W'(int'(OP_OUT) + 1), 1'b1, REG_A, '1);
      offer('1, 1'b1, '1, '0);
      wait_drain();

      // Fill past the top, then empty past the bottom.
      repeat (STACK_DEPTH + 1)
         offer(OP_PUSH, 1'($urandom_range(1)), rand_reg(), rand_value());
      repeat (STACK_DEPTH + 1) offer(OP_PULL, 1'b0, REG_A, '0);
      random_program(600);
      wait_drain();

      // Hold responses off while requests keep coming, so the block backs up.
      rsp_hold_left = 80;
      steady        = 1'b1;
      random_program(940);
      steady        = 1'b0;
      random_program(1820);

      wait_drain();
      repeat (8) @(negedge clock);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
hdl/trsc_pkg.sv
hdl/trsc_ram.sv
hdl/trsc_issue.sv
hdl/trsc_exec.sv
hdl/tiny_register_stack_cpu.sv
tb/instruction_checker.sv
tb/testbench.sv
